// File: hw/rtl/utf16_to_utf8_transcoder_top_defines.svh
// Assertion macros shared by the UTF-16 to UTF-8 transcoder modules.
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define U2U8_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication.
`define U2U8_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define U2U8_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/u2u8_pkg.sv
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_BAD_PAIR  = 2'd2,
        ST_BAD_POINT = 2'd3
    } u2u8_status_t;

    localparam int UNIT_W  = 16;
    localparam int POINT_W = 21;
    localparam int BYTE_W  = 8;

    // Surrogate ranges, decided on the top six bits of a unit.
    localparam logic [5:0] HIGH_PREFIX = 6'b110110;
    localparam logic [5:0] LOW_PREFIX  = 6'b110111;

    localparam logic [UNIT_W-1:0] MAX_ONE_BYTE = 16'h007F;
    localparam logic [UNIT_W-1:0] MAX_TWO_BYTE = 16'h07FF;
    localparam logic [POINT_W-1:0] SUPP_BASE   = 21'h10000;

    // One classified item, handed from the front to the back through the queue.
    typedef struct packed {
        logic [POINT_W-1:0] point;     // code point, zero for an error
        logic [1:0]         last_idx;  // byte count minus one
        logic               eot;       // unit carried the end-of-text mark
        u2u8_status_t       status;
    } u2u8_entry_t;

endpackage

// File: hw/rtl/u2u8_front.sv
// Front end: accepts UTF-16 units, tracks surrogate and error state, classifies items.
module u2u8_front
    import u2u8_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [UNIT_W-1:0] in_unit,
    input  logic              in_eot,
    output logic              push,
    output u2u8_entry_t       push_entry
);

    logic       pending_reg, pending_next;
    logic [9:0] held_reg, held_next;
    logic       err_reg, err_next;
    logic       accept;
    logic       is_high, is_low;
    logic       has_result;

    assign accept  = in_valid && in_ready;
    assign is_high = (in_unit[15:10] == HIGH_PREFIX);
    assign is_low  = (in_unit[15:10] == LOW_PREFIX);

    // Classify the unit against the held state.
    always_comb begin
        pending_next          = pending_reg;
        held_next             = held_reg;
        err_next              = err_reg;
        has_result            = 1'b0;
        push_entry.point      = '0;
        push_entry.last_idx   = 2'd0;
        push_entry.eot        = in_eot;
        push_entry.status     = ST_OK;
        if (err_reg) begin
            // Dropping units until the end mark.
            if (in_eot) begin
                err_next = 1'b0;
            end
        end else if (pending_reg) begin
            pending_next = 1'b0;
            held_next    = '0;
            has_result   = 1'b1;
            if (!is_low) begin
                push_entry.status = ST_BAD_PAIR;
                err_next          = !in_eot;
            end else begin
                push_entry.point    = SUPP_BASE + {1'b0, held_reg, in_unit[9:0]};
                push_entry.last_idx = 2'd3;
            end
        end else if (is_high) begin
            if (in_eot) begin
                has_result        = 1'b1;
                push_entry.status = ST_TRUNCATED;
            end else begin
                pending_next = 1'b1;
                held_next    = in_unit[9:0];
            end
        end else if (is_low) begin
            has_result        = 1'b1;
            push_entry.status = ST_BAD_POINT;
            err_next          = !in_eot;
        end else begin
            has_result       = 1'b1;
            push_entry.point = {{(POINT_W-UNIT_W){1'b0}}, in_unit};
            if (in_unit <= MAX_ONE_BYTE) begin
                push_entry.last_idx = 2'd0;
            end else if (in_unit <= MAX_TWO_BYTE) begin
                push_entry.last_idx = 2'd1;
            end else begin
                push_entry.last_idx = 2'd2;
            end
        end
    end

    assign push = accept && has_result;

    // State update on each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            held_reg    <= '0;
            err_reg     <= 1'b0;
        end else if (accept) begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
            err_reg     <= err_next;
        end
    end

endmodule

// File: hw/rtl/u2u8_queue.sv
// Short register queue between the classifying front and the byte-emitting back.
`include "utf16_to_utf8_transcoder_top_defines.svh"
module u2u8_queue
    import u2u8_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  u2u8_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output u2u8_entry_t pop_entry,
    output logic        empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    u2u8_entry_t     slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full      = (count_reg == DEPTH_CW);
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `U2U8_CHECK_IMP(a_no_overflow, push, !full || pop, "queue written while full")
    `U2U8_CHECK_IMP(a_no_underflow, pop, !empty, "queue read while empty")
    `U2U8_CHECK_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not advance")

endmodule

// File: hw/rtl/u2u8_back.sv
// Back end: drains queued code points as UTF-8 bytes through an output register.
`include "utf16_to_utf8_transcoder_top_defines.svh"
module u2u8_back
    import u2u8_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  u2u8_entry_t       q_entry,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last,
    output logic [2:0]        out_user
);

    u2u8_entry_t       cur_reg;
    logic              cur_valid_reg;
    logic [1:0]        idx_reg;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_last_reg;
    logic [2:0]        m_user_reg;
    logic              out_free;
    logic              is_last;
    logic              emit;
    logic [BYTE_W-1:0] byte_sel;

    // Select one byte of the UTF-8 encoding of a code point.
    function automatic logic [BYTE_W-1:0] utf8_byte(
        input logic [POINT_W-1:0] cp,
        input logic [1:0]         last_idx,
        input logic [1:0]         idx
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        unique case (last_idx)
            2'd0: b = cp[7:0];
            2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    assign out_free = !m_valid_reg || out_ready;
    assign is_last  = (idx_reg == cur_reg.last_idx);
    assign emit     = cur_valid_reg && out_free;
    assign q_pop    = !q_empty && (!cur_valid_reg || (emit && is_last));
    assign byte_sel = (cur_reg.status == ST_OK)
                    ? utf8_byte(cur_reg.point, cur_reg.last_idx, idx_reg) : '0;

    // Current entry and byte index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (q_pop) begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (emit) begin
            if (is_last) begin
                cur_valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_entry;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg <= byte_sel;
            m_last_reg <= is_last;
            m_user_reg <= {cur_reg.status, cur_reg.eot && is_last};
        end
    end

    assign out_valid = m_valid_reg;
    assign out_byte  = m_byte_reg;
    assign out_last  = m_last_reg;
    assign out_user  = m_user_reg;

    `U2U8_CHECK_IMP(a_error_single, m_valid_reg && m_user_reg[2:1] != ST_OK, m_last_reg && m_byte_reg == '0, "error item not a single zero byte")
    `U2U8_CHECK_IMP(a_end_is_last, m_valid_reg && m_user_reg[0], m_last_reg, "text end without run end")
    `U2U8_CHECK_IMP(a_idx_range, cur_valid_reg, idx_reg <= cur_reg.last_idx, "byte index past run")

endmodule

// File: hw/rtl/utf16_to_utf8_transcoder_top.sv
// UTF-16 to UTF-8 transcoder: input stream, classifying front, queue, byte-emitting back.
//
// Input channel s_axis: one UTF-16 code unit per item in tdata, tlast set on the
// last unit of a text. Output channel m_axis: one UTF-8 byte per item in tdata,
// tlast on the final byte caused by one input unit, tuser carrying the text-end
// flag and a two-bit status (0 ok, 1 truncated surrogate, 2 broken pair, 3 lone
// low surrogate). An error gives a single zero byte, after which units are
// dropped up to and including the next end-marked one.
// Each item passes a queue slot, the current-entry register and the output register.
// Throughput: one input unit per cycle while each unit makes one byte and the
// receiver does not stall; a multi-byte point holds the byte emitter until its last
// byte is out, so the rate is set by the output byte count. A high surrogate is
// taken with no output. A queue of QUEUE_DEPTH entries sits between front and back,
// so input keeps flowing while a multi-byte run drains or the receiver stalls;
// s_axis_tready falls only when that queue is full. A stalled output byte holds
// in place. Reset clears the surrogate and error state, empties the queue and drops
// any byte in flight.
module utf16_to_utf8_transcoder_top
    import u2u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // last_of_run
    output logic [2:0]  m_axis_tuser    // [0] text_end, [2:1] status
);

    logic        push;
    u2u8_entry_t push_entry;
    logic        q_full;
    logic        q_pop;
    u2u8_entry_t q_entry;
    logic        q_empty;

    assign s_axis_tready = !q_full;

    // Classify units and keep surrogate state.
    u2u8_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_unit    (s_axis_tdata),
        .in_eot     (s_axis_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue.
    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .empty      (q_empty)
    );

    // Emit UTF-8 bytes.
    u2u8_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

endmodule
